### rtl/calendar_time_to_epoch_seconds_macros.svh
// assertion macros for the calendar to epoch seconds block
// no dependencies; included by files that carry concurrent checks
`ifndef CALENDAR_TIME_TO_EPOCH_SECONDS_MACROS_SVH
`define CALENDAR_TIME_TO_EPOCH_SECONDS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CTE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// general property, clocked and reset-disabled
`define CTE_ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### rtl/cte_pkg.sv
// shared widths, constants, stage structs and the month table
// used by cte_norm, cte_days and the top level; no dependencies
package cte_pkg;

  localparam int YEAR_W  = 14;
  // corrected year plus month carry can pass the 14-bit input range
  localparam int FYEAR_W = 15;
  localparam int MON_W   = 8;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MIDX_W  = 4;
  localparam int TOD_W   = 17;
  localparam int DAYS_W  = 23;
  localparam int EPOCH_W = 39;

  localparam int SHORT_YEAR_MAX     = 2000;
  localparam int SHORT_YEAR_OFFSET  = 1998;
  localparam int EPOCH_YEAR         = 1970;
  localparam int LEAPS_BEFORE_EPOCH = 477;
  localparam int DAYS_PER_YEAR      = 365;
  localparam int MONTHS_PER_YEAR    = 12;
  localparam int CENTURY            = 100;
  localparam int SECS_PER_HOUR      = 3600;
  localparam int SECS_PER_MIN       = 60;
  localparam int SECS_PER_DAY       = 86400;

  // reciprocal multipliers for constant division
  localparam int RECIP_12     = 171;
  localparam int RECIP_12_SH  = 11;
  localparam int RECIP_100    = 5243;
  localparam int RECIP_100_SH = 19;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [FYEAR_W-1:0] fyear_t;
  typedef logic [MIDX_W-1:0]  midx_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [TOD_W-1:0]   tod_t;
  typedef logic [DAYS_W-1:0]  days_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    fyear_t year;
    midx_t  midx;
    day_t   day;
    tod_t   tod;
  } norm_t;

  typedef struct packed {
    days_t days;
    tod_t  tod;
  } days_stage_t;

  // days before each month of a common year
  function automatic logic [8:0] days_before_month(input midx_t m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/cte_norm.sv
// year correction, month wrap with year carry, time-of-day seconds
// depends on cte_pkg
module cte_norm (
  input  logic [cte_pkg::YEAR_W-1:0] calendar_year,
  input  logic [cte_pkg::MON_W-1:0]  month_number,
  input  logic [cte_pkg::DAY_W-1:0]  day_of_month,
  input  logic [cte_pkg::HOUR_W-1:0] hour_of_day,
  input  logic [cte_pkg::MIN_W-1:0]  minute_of_hour,
  input  logic [cte_pkg::SEC_W-1:0]  second_of_minute,
  output cte_pkg::norm_t             norm
);

  cte_pkg::fyear_t           full;
  logic [cte_pkg::MON_W-1:0] m;
  logic [15:0]               m_prod;
  logic [4:0]                carry;
  logic [cte_pkg::MON_W-1:0] carry_x12;

  always_comb begin
    full = (calendar_year > cte_pkg::year_t'(cte_pkg::SHORT_YEAR_MAX))
         ? cte_pkg::fyear_t'(calendar_year)
         : cte_pkg::fyear_t'(calendar_year) + cte_pkg::fyear_t'(cte_pkg::SHORT_YEAR_OFFSET);
    m = month_number - 8'd1;
    // m / 12 by reciprocal, exact for all 8-bit m
    m_prod    = 16'(m) * 16'(cte_pkg::RECIP_12);
    carry     = 5'(m_prod >> cte_pkg::RECIP_12_SH);
    carry_x12 = 8'(carry) * 8'(cte_pkg::MONTHS_PER_YEAR);
    norm.year = full + cte_pkg::fyear_t'(carry);
    norm.midx = cte_pkg::midx_t'(m - carry_x12);
    norm.day  = day_of_month;
    norm.tod  = cte_pkg::tod_t'(hour_of_day) * cte_pkg::tod_t'(cte_pkg::SECS_PER_HOUR)
              + cte_pkg::tod_t'(minute_of_hour) * cte_pkg::tod_t'(cte_pkg::SECS_PER_MIN)
              + cte_pkg::tod_t'(second_of_minute);
  end

endmodule

### rtl/cte_days.sv
// day count since the epoch from normalized year, month and day
// depends on cte_pkg
module cte_days (
  input  cte_pkg::norm_t       norm,
  output cte_pkg::days_stage_t dst
);

  cte_pkg::fyear_t p;
  cte_pkg::fyear_t yoff;
  logic [26:0]     p_prod;
  logic [26:0]     f_prod;
  logic [7:0]      q100p;
  logic [7:0]      q100f;
  logic [6:0]      r100f;
  logic [12:0]     lb;
  logic            leap;
  logic            leap_add;

  always_comb begin
    p      = norm.year - cte_pkg::fyear_t'(1);
    // p / 100 and year / 100 by reciprocal, exact below 25600
    p_prod = 27'(p) * 27'(cte_pkg::RECIP_100);
    f_prod = 27'(norm.year) * 27'(cte_pkg::RECIP_100);
    q100p  = 8'(p_prod >> cte_pkg::RECIP_100_SH);
    q100f  = 8'(f_prod >> cte_pkg::RECIP_100_SH);
    r100f  = 7'(norm.year - cte_pkg::fyear_t'(q100f) * cte_pkg::fyear_t'(cte_pkg::CENTURY));
    // leap days in years 1 .. year-1
    lb     = 13'(p >> 2) - 13'(q100p) + 13'(q100p >> 2);
    leap   = (norm.year[1:0] == 2'd0) && ((r100f != 7'd0) || (q100f[1:0] == 2'd0));
    leap_add = leap && (norm.midx >= cte_pkg::midx_t'(2));
    yoff   = norm.year - cte_pkg::fyear_t'(cte_pkg::EPOCH_YEAR);
    dst.days = cte_pkg::days_t'(yoff) * cte_pkg::days_t'(cte_pkg::DAYS_PER_YEAR)
             + cte_pkg::days_t'(lb)
             + cte_pkg::days_t'(cte_pkg::days_before_month(norm.midx))
             + cte_pkg::days_t'(leap_add)
             + cte_pkg::days_t'(norm.day)
             - cte_pkg::days_t'(cte_pkg::LEAPS_BEFORE_EPOCH + 1);
    dst.tod  = norm.tod;
  end

endmodule

### rtl/calendar_time_to_epoch_seconds.sv
// calendar reading to seconds since 1970-01-01; four register stages
// done is registered from v2; an accepted reading passes v0, v1 and v2 in that order
// throughput: one reading per cycle, busy is always low, the receiver cannot stall
// reset: synchronous active-high rst clears the stage valid bits and done
// depends on cte_pkg, cte_norm, cte_days and the assertion macro header
`include "calendar_time_to_epoch_seconds_macros.svh"
module calendar_time_to_epoch_seconds (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [cte_pkg::YEAR_W-1:0]  calendar_year,
  input  logic [cte_pkg::MON_W-1:0]   month_number,
  input  logic [cte_pkg::DAY_W-1:0]   day_of_month,
  input  logic [cte_pkg::HOUR_W-1:0]  hour_of_day,
  input  logic [cte_pkg::MIN_W-1:0]   minute_of_hour,
  input  logic [cte_pkg::SEC_W-1:0]   second_of_minute,
  output logic                        done,
  output logic [cte_pkg::EPOCH_W-1:0] epoch_seconds
);

  // input register
  logic                        v0;
  logic [cte_pkg::YEAR_W-1:0]  yr0;
  logic [cte_pkg::MON_W-1:0]   mon0;
  logic [cte_pkg::DAY_W-1:0]   day0;
  logic [cte_pkg::HOUR_W-1:0]  hr0;
  logic [cte_pkg::MIN_W-1:0]   mn0;
  logic [cte_pkg::SEC_W-1:0]   sc0;

  logic                 v1;
  cte_pkg::norm_t       norm1;
  cte_pkg::norm_t       norm_next;
  logic                 v2;
  cte_pkg::days_stage_t dst2;
  cte_pkg::days_stage_t dst_next;

  assign busy = 1'b0;

  cte_norm u_norm (
    .calendar_year    (yr0),
    .month_number     (mon0),
    .day_of_month     (day0),
    .hour_of_day      (hr0),
    .minute_of_hour   (mn0),
    .second_of_minute (sc0),
    .norm             (norm_next)
  );

  cte_days u_days (
    .norm (norm1),
    .dst  (dst_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      v2   <= v1;
      done <= v2;
    end
    yr0   <= calendar_year;
    mon0  <= month_number;
    day0  <= day_of_month;
    hr0   <= hour_of_day;
    mn0   <= minute_of_hour;
    sc0   <= second_of_minute;
    norm1 <= norm_next;
    dst2  <= dst_next;
    // days times seconds per day, then time of day
    epoch_seconds <= cte_pkg::epoch_t'(dst2.days) * cte_pkg::epoch_t'(cte_pkg::SECS_PER_DAY)
                   + cte_pkg::epoch_t'(dst2.tod);
  end

  `CTE_ASSERT_PROP(a_beat_out, clk, rst, (start && !busy) |-> ##4 done, "accepted beat lost")
  `CTE_ASSERT_IMP(a_no_extra, clk, rst, done, $past(start, 4), "result without a beat")
  `CTE_ASSERT_IMP(a_midx_range, clk, rst, v1, norm1.midx < cte_pkg::midx_t'(12), "month index out of range")

endmodule

### test/calendar_time_to_epoch_seconds_tb.sv
// testbench for calendar_time_to_epoch_seconds: directed and random clock readings
// checked against a local seconds-since-1970 predictor; needs cte_pkg and the block
`timescale 1ns / 1ps

module calendar_time_to_epoch_seconds_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SECS_PER_YEAR  = 31536000;
  localparam int unsigned MONTH_START_DAY [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef logic [cte_pkg::MON_W-1:0]  mon_t;
  typedef logic [cte_pkg::HOUR_W-1:0] hour_t;
  typedef logic [cte_pkg::MIN_W-1:0]  min_t;
  typedef logic [cte_pkg::SEC_W-1:0]  sec_t;

  typedef struct packed {
    cte_pkg::year_t year;
    mon_t           month;
    cte_pkg::day_t  day;
    hour_t          hour;
    min_t           minute;
    sec_t           second;
  } reading_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  cte_pkg::year_t  calendar_year;
  mon_t            month_number;
  cte_pkg::day_t   day_of_month;
  hour_t           hour_of_day;
  min_t            minute_of_hour;
  sec_t            second_of_minute;
  logic            done;
  cte_pkg::epoch_t epoch_seconds;

  cte_pkg::epoch_t pending_epochs[$];
  cte_pkg::epoch_t want_epoch;
  int              gap_pct;
  int              readings_sent;
  int              results_seen;
  int              fail_count;
  int              quiet_cycles;

  calendar_time_to_epoch_seconds dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .calendar_year    (calendar_year),
    .month_number     (month_number),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .done             (done),
    .epoch_seconds    (epoch_seconds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // leap days in years 1 .. y-1
  function automatic longint unsigned leap_days_before_year(input longint unsigned y);
    longint unsigned p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  function automatic bit is_leap(input longint unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % cte_pkg::CENTURY == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic cte_pkg::epoch_t expected_epoch(input reading_t r);
    longint unsigned full_year;
    longint unsigned mon;
    longint unsigned secs;
    full_year = (r.year > cte_pkg::SHORT_YEAR_MAX)
              ? longint'(r.year)
              : longint'(r.year) + cte_pkg::SHORT_YEAR_OFFSET;
    // month minus one wraps at 8 bits, overflow carries whole years
    mon = (longint'(r.month) + 255) % 256;
    full_year += mon / cte_pkg::MONTHS_PER_YEAR;
    mon = mon % cte_pkg::MONTHS_PER_YEAR;
    secs = (full_year - cte_pkg::EPOCH_YEAR) * SECS_PER_YEAR;
    secs += (leap_days_before_year(full_year) - leap_days_before_year(cte_pkg::EPOCH_YEAR))
            * cte_pkg::SECS_PER_DAY;
    secs += MONTH_START_DAY[mon] * cte_pkg::SECS_PER_DAY;
    if (mon >= 2 && is_leap(full_year)) secs += cte_pkg::SECS_PER_DAY;
    secs += longint'(r.day) * cte_pkg::SECS_PER_DAY;
    secs -= cte_pkg::SECS_PER_DAY;
    secs += longint'(r.hour) * cte_pkg::SECS_PER_HOUR
            + longint'(r.minute) * cte_pkg::SECS_PER_MIN
            + longint'(r.second);
    return cte_pkg::epoch_t'(secs);
  endfunction

  function automatic reading_t make_reading(input int unsigned y, input int unsigned m,
                                            input int unsigned d, input int unsigned h,
                                            input int unsigned mi, input int unsigned s);
    reading_t r;
    r.year   = cte_pkg::year_t'(y);
    r.month  = mon_t'(m);
    r.day    = cte_pkg::day_t'(d);
    r.hour   = hour_t'(h);
    r.minute = min_t'(mi);
    r.second = sec_t'(s);
    return r;
  endfunction

  function automatic reading_t random_reading();
    reading_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) r.year = cte_pkg::year_t'($urandom_range(cte_pkg::SHORT_YEAR_MAX));
    else if (pick < 60) r.year = cte_pkg::year_t'($urandom_range(2100, 2001));
    else if (pick < 70) r.year = cte_pkg::year_t'($urandom_range(2002, 1999));
    else r.year = cte_pkg::year_t'($urandom_range((1 << cte_pkg::YEAR_W) - 1));
    r.month  = mon_t'(($urandom_range(99) < 80) ? $urandom_range(12, 1)
                                                : $urandom_range(255));
    r.day    = cte_pkg::day_t'(($urandom_range(99) < 80) ? $urandom_range(28, 1)
                                                         : $urandom_range(31));
    r.hour   = hour_t'(($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(31));
    r.minute = min_t'(($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(63));
    r.second = sec_t'(($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(63));
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // start stays high across back-to-back beats; a gap lowers it before the next reading is driven
  task automatic send_reading(input reading_t r);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    calendar_year    <= r.year;
    month_number     <= r.month;
    day_of_month     <= r.day;
    hour_of_day      <= r.hour;
    minute_of_hour   <= r.minute;
    second_of_minute <= r.second;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_epochs.push_back(expected_epoch(r));
    readings_sent++;
  endtask

  task automatic test_field_extremes();
    send_reading(make_reading(0, 1, 1, 0, 0, 0));
    send_reading(make_reading((1 << cte_pkg::YEAR_W) - 1, 255, 31, 31, 63, 63));
    send_reading(make_reading(0, 0, 0, 0, 0, 0));
    send_reading(make_reading(2024, 6, 0, 31, 63, 63));
  endtask

  task automatic test_year_correction();
    send_reading(make_reading(1, 1, 1, 0, 0, 0));
    send_reading(make_reading(1999, 7, 4, 12, 30, 30));
    send_reading(make_reading(cte_pkg::SHORT_YEAR_MAX, 1, 1, 0, 0, 0));
    send_reading(make_reading(cte_pkg::SHORT_YEAR_MAX + 1, 1, 1, 0, 0, 0));
    send_reading(make_reading(2038, 1, 19, 3, 14, 7));
    send_reading(make_reading(2039, 1, 1, 0, 0, 0));
  endtask

  task automatic test_month_wrap();
    send_reading(make_reading(2010, 12, 31, 23, 59, 59));
    send_reading(make_reading(2010, 13, 1, 0, 0, 0));
    send_reading(make_reading(2010, 24, 15, 8, 0, 0));
    send_reading(make_reading(2010, 25, 15, 8, 0, 0));
    send_reading(make_reading(2010, 255, 1, 0, 0, 0));
  endtask

  task automatic test_leap_days();
    send_reading(make_reading(2004, 2, 29, 0, 0, 0));
    send_reading(make_reading(2004, 3, 1, 0, 0, 0));
    send_reading(make_reading(2100, 3, 1, 0, 0, 0));
    send_reading(make_reading(2400, 3, 1, 0, 0, 0));
    // short year two lands on 2000, a 400-year leap
    send_reading(make_reading(2, 3, 1, 0, 0, 0));
    send_reading(make_reading(2023, 3, 1, 0, 0, 0));
  endtask

  task automatic test_random_readings(input int count, input int pct);
    gap_pct = pct;
    repeat (count) send_reading(random_reading());
    gap_pct = 0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (pending_epochs.size() == 0) begin
        note_failure($sformatf("result %0d with nothing expected", epoch_seconds));
      end else begin
        want_epoch = pending_epochs.pop_front();
        if (epoch_seconds !== want_epoch)
          note_failure($sformatf("epoch_seconds expected %0d actual %0d",
                                 want_epoch, epoch_seconds));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    start            <= 1'b0;
    calendar_year    <= '0;
    month_number     <= '0;
    day_of_month     <= '0;
    hour_of_day      <= '0;
    minute_of_hour   <= '0;
    second_of_minute <= '0;
    gap_pct          = 0;
    readings_sent    = 0;
    results_seen     = 0;
    fail_count       = 0;
    quiet_cycles     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_year_correction();
    test_month_wrap();
    test_leap_days();
    test_random_readings(300, 0);
    test_random_readings(300, 47);
    test_random_readings(300, 0);
    test_random_readings(300, 30);
    start <= 1'b0;

    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_epochs.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_epochs.size()));

    $display("covered %0d readings (year correction, month wrap, leap days, extremes)",
             readings_sent);
    $display("%0d results checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cte_pkg.sv
rtl/cte_norm.sv
rtl/cte_days.sv
rtl/calendar_time_to_epoch_seconds.sv
test/calendar_time_to_epoch_seconds_tb.sv
